// ===== hdl/octree_box_key_compare_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the octree box key compare block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OCTREE_BOX_KEY_COMPARE_ASSERT_SVH
`define OCTREE_BOX_KEY_COMPARE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define OKBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define OKBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/okbc_pkg.sv =====
// ----------------------------------------------------------------------------
// okbc_pkg
// Types, constants and helper functions shared by the box key compare block.
// ----------------------------------------------------------------------------
`default_nettype none

package okbc_pkg;

    // Field widths
    localparam int CRD_W     = 31;
    localparam int N_CRD     = 12;
    localparam int DIFF_W    = 6;
    localparam int REL_W     = 3;
    localparam int S_TDATA_W = ((N_CRD * CRD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((REL_W + 7) / 8) * 8;

    // Parameter defaults
    localparam int              LEVELS_DEF      = 48;
    localparam longint unsigned COORD_LIMIT_DEF = 64'd1073741823;

    // Saturation bound of the prefix differences
    localparam logic signed [DIFF_W-1:0] DIFF_SAT = 6'sd16;
    localparam logic signed [DIFF_W-1:0] DIFF_TWO = 6'sd2;

    // Relation codes
    localparam logic signed [REL_W-1:0] REL_LT2 = -3'sd2;
    localparam logic signed [REL_W-1:0] REL_LT1 = -3'sd1;
    localparam logic signed [REL_W-1:0] REL_EQ  = 3'sd0;
    localparam logic signed [REL_W-1:0] REL_GT1 = 3'sd1;
    localparam logic signed [REL_W-1:0] REL_GT2 = 3'sd2;

    // One comparison in flight
    typedef struct packed {
        logic                         done;
        logic signed [REL_W-1:0]      rel;
        logic signed [DIFF_W-1:0]     e02;
        logic signed [DIFF_W-1:0]     e12;
        logic signed [DIFF_W-1:0]     e13;
        logic signed [DIFF_W-1:0]     e03;
        logic [N_CRD-1:0][CRD_W-1:0]  crd;
    } item_t;

    // Difference of two octant codes
    function automatic logic signed [3:0] oct_delta(input logic [2:0] hi, input logic [2:0] lo);
        return $signed({1'b0, hi}) - $signed({1'b0, lo});
    endfunction

    // Shift a prefix difference by one level, add the octant delta and saturate
    function automatic logic signed [DIFF_W-1:0] sat_shift(
        input logic signed [DIFF_W-1:0] d,
        input logic signed [3:0]        delta
    );
        logic signed [8:0] c;
        c = (9'(d) <<< 3) + 9'(delta);
        if (c > 9'(DIFF_SAT))
            return DIFF_SAT;
        else if (c < -9'(DIFF_SAT))
            return -DIFF_SAT;
        else
            return c[DIFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/octree_box_key_compare.sv =====
// A request passes through the level cells in order, then the final output register.
// Throughput: one request per cycle unless a result waits; one cell per octree level.
// A stalled result freezes the whole chain and input ready drops with it.
// Reset (rst_n low, asynchronous) clears all valid bits; the chain is empty.
// ----------------------------------------------------------------------------
// octree_box_key_compare
// Five-way relation of two 3D boxes by octree descent, one level per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module octree_box_key_compare
    import okbc_pkg::*;
#(
    parameter int              LEVELS      = LEVELS_DEF,
    parameter longint unsigned COORD_LIMIT = COORD_LIMIT_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // a_low_x, a_low_y, a_low_z, a_high_x, a_high_y, a_high_z,
    // b_low_x, b_low_y, b_low_z, b_high_x, b_high_y, b_high_z (31 bits each)
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // relation (low 3 bits, upper bits zero)
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int              KEY_W = (N_CRD / 2) * CRD_W;
    localparam longint unsigned STEP0 = (COORD_LIMIT + 64'd1) / 64'd2;

    logic                    advance;
    logic                    same;
    logic [LEVELS:0]         chain_valid;
    item_t                   chain_item [LEVELS+1];
    logic signed [REL_W-1:0] relation;

    // Whole chain moves unless a result waits
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Identical keys are decided before the first level
    assign same = (s_tdata[KEY_W-1:0] == s_tdata[2*KEY_W-1:KEY_W]);

    always_comb
    begin
        chain_item[0].done = same;
        chain_item[0].rel  = REL_EQ;
        chain_item[0].e02  = '0;
        chain_item[0].e12  = '0;
        chain_item[0].e13  = '0;
        chain_item[0].e03  = '0;
        chain_item[0].crd  = s_tdata[N_CRD*CRD_W-1:0];
    end
    assign chain_valid[0] = s_tvalid;

    // Level cells
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        okbc_cell #(
            .STEP (STEP0 >> g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // Final comparison and output register
    okbc_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (chain_valid[LEVELS]),
        .in_item   (chain_item[LEVELS]),
        .out_valid (m_tvalid),
        .relation  (relation)
    );

    assign m_tdata = {{(M_TDATA_W - REL_W){1'b0}}, relation};

endmodule

`default_nettype wire

// ===== hdl/okbc_cell.sv =====
// ----------------------------------------------------------------------------
// okbc_cell
// One octree level: octants of all four corners, difference update and the
// early-exit rules. Registered, handing its item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module okbc_cell
    import okbc_pkg::*;
#(
    parameter longint unsigned STEP = (COORD_LIMIT_DEF + 64'd1) / 64'd2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire item_t in_item,
    output logic       out_valid,
    output item_t      out_item
);

    localparam logic [CRD_W:0] STEP_V = (CRD_W + 1)'(STEP);

    logic              valid_reg;
    item_t             item_reg;
    item_t             item_next;
    logic [3:0][2:0]   oct;
    logic signed [DIFF_W-1:0] e02_n, e12_n, e13_n, e03_n;

    // Octants, coordinate update and decision
    always_comb
    begin
        logic [CRD_W:0] ext;
        logic [CRD_W:0] sum;
        item_next = in_item;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                oct[k][j] = ~in_item.crd[k*3+j][CRD_W-1];
                ext = {in_item.crd[k*3+j][CRD_W-1], in_item.crd[k*3+j]};
                sum = oct[k][j] ? (ext - STEP_V) : (ext + STEP_V);
                item_next.crd[k*3+j] = sum[CRD_W-1:0];
            end
        end

        e02_n = sat_shift(in_item.e02, oct_delta(oct[2], oct[0]));
        e12_n = sat_shift(in_item.e12, oct_delta(oct[2], oct[1]));
        e13_n = sat_shift(in_item.e13, oct_delta(oct[3], oct[1]));
        e03_n = sat_shift(in_item.e03, oct_delta(oct[3], oct[0]));

        if (!in_item.done)
        begin
            item_next.e02 = e02_n;
            item_next.e12 = e12_n;
            item_next.e13 = e13_n;
            item_next.e03 = e03_n;
            item_next.done = 1'b1;
            if (e02_n >= DIFF_TWO && e12_n >= DIFF_TWO)
                item_next.rel = REL_LT2;
            else if (e02_n >= DIFF_TWO && e13_n >= DIFF_TWO)
                item_next.rel = REL_LT1;
            else if (e03_n <= -DIFF_TWO && e13_n <= -DIFF_TWO)
                item_next.rel = REL_GT2;
            else if (e02_n <= -DIFF_TWO && e13_n <= -DIFF_TWO)
                item_next.rel = REL_GT1;
            else if (e02_n >= DIFF_TWO && e13_n <= -DIFF_TWO)
                item_next.rel = REL_EQ;
            else if (e02_n <= -DIFF_TWO && e13_n >= DIFF_TWO)
                item_next.rel = REL_EQ;
            else
                item_next.done = 1'b0;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/okbc_final.sv =====
// ----------------------------------------------------------------------------
// okbc_final
// Passes on earlier decisions; exact comparison of the full codes for items still
// undecided after the last level; holds the result for the output request.
// ----------------------------------------------------------------------------
`default_nettype none

module okbc_final
    import okbc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire item_t              in_item,
    output logic                    out_valid,
    output logic signed [REL_W-1:0] relation
);

    localparam logic signed [DIFF_W-1:0] DIFF_ZERO = '0;

    logic                    valid_reg;
    logic signed [REL_W-1:0] rel_reg;
    logic signed [REL_W-1:0] rel_next;

    // Final rules without slack
    always_comb
    begin
        if (in_item.done)
            rel_next = in_item.rel;
        else if (in_item.e02 > DIFF_ZERO && in_item.e12 > DIFF_ZERO)
            rel_next = REL_LT2;
        else if (in_item.e02 > DIFF_ZERO && in_item.e13 > DIFF_ZERO)
            rel_next = REL_LT1;
        else if (in_item.e03 < DIFF_ZERO && in_item.e13 < DIFF_ZERO)
            rel_next = REL_GT2;
        else if (in_item.e02 < DIFF_ZERO && in_item.e13 < DIFF_ZERO)
            rel_next = REL_GT1;
        else
            rel_next = REL_EQ;
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (en)
            rel_reg <= rel_next;
    end

    assign out_valid = valid_reg;
    assign relation  = rel_reg;

endmodule

`default_nettype wire

// ===== hdl/okbc_chk.sv =====
// ----------------------------------------------------------------------------
// okbc_chk
// Port-level checks of the box key compare block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "octree_box_key_compare_assert.svh"

module okbc_chk
    import okbc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // Relation field of the result
    logic signed [REL_W-1:0] rel_out;
    assign rel_out = m_tdata[REL_W-1:0];

    // Result code stays within the five relations
    `OKBC_ASSERT_NOW(a_rel_range, m_tvalid, rel_out >= REL_LT2 && rel_out <= REL_GT2, "bad relation")

    // Padding bits of the result stay zero
    `OKBC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:REL_W] == '0, "padding not zero")

    // A waiting result blocks new requests
    `OKBC_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "request taken in stall")

    // A stalled result holds
    `OKBC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result moved")

endmodule

bind octree_box_key_compare okbc_chk u_okbc_chk (.*);

`default_nettype wire
